@@ rtl/osm_pkg.sv @@
// osm_pkg: shared types, codes and helper functions of the single-wire sensor master
// used by every module of the unit; depends on nothing
`default_nettype none

package osm_pkg;

   localparam logic [2:0] OP_CONVERT      = 3'd0;
   localparam logic [2:0] OP_READ_TEMP    = 3'd1;
   localparam logic [2:0] OP_WRITE_LIMITS = 3'd2;
   localparam logic [2:0] OP_READ_LIMITS  = 3'd3;
   localparam logic [2:0] OP_SAVE         = 3'd4;

   localparam logic [7:0] CMD_SKIP_ROM    = 8'hcc;
   localparam logic [7:0] CMD_CONVERT     = 8'h44;
   localparam logic [7:0] CMD_READ_PAD    = 8'hbe;
   localparam logic [7:0] CMD_WRITE_PAD   = 8'h4e;
   localparam logic [7:0] CMD_COPY_PAD    = 8'h48;
   localparam logic [4:0] CFG_BYTE_FILL   = 5'h1f;

   localparam int unsigned READ_BYTES     = 5;
   localparam int unsigned FIRST_READ     = 2;

   localparam logic [2:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] CSR_RECOVERY      = 3'd2;
   localparam logic [2:0] CSR_SLOT          = 3'd3;
   localparam logic [2:0] CSR_STORE_WAIT    = 3'd4;

   localparam logic [6:0] RESET_LOW_INIT     = 7'd60;
   localparam logic [4:0] PRESENCE_WAIT_INIT = 5'd12;
   localparam logic [5:0] RECOVERY_INIT      = 6'd24;
   localparam logic [3:0] SLOT_INIT          = 4'd5;
   localparam logic [7:0] STORE_WAIT_INIT    = 8'd12;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RESET,
      PH_PRESENCE,
      PH_RECOVERY,
      PH_SLOT,
      PH_STORE
   } phase_type;

   typedef struct packed {
      logic [6:0] reset_low_ticks;
      logic [4:0] presence_wait_ticks;
      logic [5:0] recovery_ticks;
      logic [3:0] slot_ticks;
      logic [7:0] store_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic       start_req;
      logic [2:0] kind;
      logic [7:0] upper_limit;
      logic [7:0] lower_limit;
      logic [1:0] resolution_in;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic               line_drive;
      logic               busy_res;
      logic               done_res;
      logic               no_device;
      logic signed [15:0] temperature;
      logic [7:0]         upper_limit_out;
      logic [7:0]         lower_limit_out;
      logic [2:0]         resolution_out;
   } res_type;

   // bytes sent before any read
   function automatic logic [2:0] write_count(input logic [2:0] op);
      return (op == OP_WRITE_LIMITS) ? 3'd5 : 3'd2;
   endfunction

   // bytes sent plus bytes read
   function automatic logic [2:0] total_count(input logic [2:0] op);
      logic [2:0] cnt;
      case (op)
         OP_READ_TEMP:    cnt = 3'd4;
         OP_WRITE_LIMITS: cnt = 3'd5;
         OP_READ_LIMITS:  cnt = 3'd7;
         default:         cnt = 3'd2;
      endcase
      return cnt;
   endfunction

   function automatic logic [7:0] write_value(input logic [2:0]  op,
                                              input logic [2:0]  idx,
                                              input logic [17:0] lat);
      logic [7:0] val;
      case (idx)
         3'd0: val = CMD_SKIP_ROM;
         3'd1: begin
            priority if (op == OP_CONVERT)      val = CMD_CONVERT;
            else if (op == OP_WRITE_LIMITS)     val = CMD_WRITE_PAD;
            else if (op == OP_SAVE)             val = CMD_COPY_PAD;
            else                                val = CMD_READ_PAD;
         end
         3'd2: val = lat[17:10];
         3'd3: val = lat[9:2];
         default: val = {1'b0, lat[1:0], CFG_BYTE_FILL};
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ rtl/onewire_sensor_master_unit.sv @@
// Single-wire bus master for a temperature sensor. Each req word is one 10 us tick carrying
// the sampled line level and an optional start request; each tick returns one rsp word with
// the line drive, status and the last read-back bytes. One word is taken every clock cycle
// while the rsp side keeps up: the sequencer state and the result register both update in the
// cycle a word is taken, and rsp shows the result in the next cycle. req_ready drops only
// while a result waits in the result register and rsp_ready is low. Timing registers are
// written through csr_ and should be changed only between transactions.
// depends on osm_pkg, osm_csr, osm_seq, osm_rsp
`default_nettype none

module onewire_sensor_master_unit
   import osm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_start_req,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_upper_limit,
   input  wire logic [7:0]  req_lower_limit,
   input  wire logic [1:0]  req_resolution_in,
   input  wire logic        req_line_level,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_line_drive,
   output      logic        rsp_busy_res,
   output      logic        rsp_done_res,
   output      logic        rsp_no_device,
   output      logic signed [15:0] rsp_temperature,
   output      logic [7:0]  rsp_upper_limit_out,
   output      logic [7:0]  rsp_lower_limit_out,
   output      logic [2:0]  rsp_resolution_out
);

   cfg_type cfg;
   req_type req;
   res_type seq_res;
   res_type out_res;
   logic    item_take;

   assign req.start_req     = req_start_req;
   assign req.kind          = req_kind;
   assign req.upper_limit   = req_upper_limit;
   assign req.lower_limit   = req_lower_limit;
   assign req.resolution_in = req_resolution_in;
   assign req.line_level    = req_line_level;

   osm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   osm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .item_take (item_take),
      .req       (req),
      .cfg       (cfg),
      .res       (seq_res)
   );

   osm_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .item_take (item_take),
      .res_in    (seq_res),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .res_out   (out_res)
   );

   assign rsp_line_drive      = out_res.line_drive;
   assign rsp_busy_res        = out_res.busy_res;
   assign rsp_done_res        = out_res.done_res;
   assign rsp_no_device       = out_res.no_device;
   assign rsp_temperature     = out_res.temperature;
   assign rsp_upper_limit_out = out_res.upper_limit_out;
   assign rsp_lower_limit_out = out_res.lower_limit_out;
   assign rsp_resolution_out  = out_res.resolution_out;

endmodule

`default_nettype wire

@@ rtl/osm_csr.sv @@
// osm_csr: timing registers of the single-wire sensor master
// depends on osm_pkg
`default_nettype none

module osm_csr
   import osm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   output      cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RESET_LOW:     cfg_in.reset_low_ticks     = csr_wdata[6:0];
            CSR_PRESENCE_WAIT: cfg_in.presence_wait_ticks = csr_wdata[4:0];
            CSR_RECOVERY:      cfg_in.recovery_ticks      = csr_wdata[5:0];
            CSR_SLOT:          cfg_in.slot_ticks          = csr_wdata[3:0];
            CSR_STORE_WAIT:    cfg_in.store_wait_ticks    = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RESET_LOW_INIT;
         cfg_ff.presence_wait_ticks <= PRESENCE_WAIT_INIT;
         cfg_ff.recovery_ticks      <= RECOVERY_INIT;
         cfg_ff.slot_ticks          <= SLOT_INIT;
         cfg_ff.store_wait_ticks    <= STORE_WAIT_INIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/osm_seq.sv @@
// osm_seq: bus sequencer, one tick per accepted word: reset pulse, presence check,
// bit slots for command and read-back bytes, store wait; depends on osm_pkg
`default_nettype none

module osm_seq
   import osm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    item_take,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output      res_type res
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  tick_ff, tick_in;
   logic [2:0]  bit_ff, bit_in;
   logic [2:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  op_ff, op_in;
   logic [17:0] lat_ff, lat_in;
   logic [7:0]  rb_ff [READ_BYTES];
   logic [7:0]  rb_in [READ_BYTES];
   logic        missing_ff, missing_in;

   logic        take_start;
   phase_type   cur_phase;
   logic [2:0]  cur_op;
   logic [17:0] cur_lat;
   logic [7:0]  cur_tick;
   logic [2:0]  cur_bit;
   logic [2:0]  cur_byte;
   logic [7:0]  tick_inc;
   logic        writing;
   logic [7:0]  shift_rd;
   logic [7:0]  shift_done;
   logic [2:0]  next_byte;
   logic [2:0]  rb_idx;
   logic [6:0]  rst_len;
   logic [5:0]  rec_len;
   logic [3:0]  slot_len;
   logic [7:0]  store_len;
   logic        drive;
   logic        busy;
   logic        done;

   // zero lengths act as one
   assign rst_len   = (cfg.reset_low_ticks == 7'd0) ? 7'd1 : cfg.reset_low_ticks;
   assign rec_len   = (cfg.recovery_ticks == 6'd0) ? 6'd1 : cfg.recovery_ticks;
   assign slot_len  = (cfg.slot_ticks == 4'd0) ? 4'd1 : cfg.slot_ticks;
   assign store_len = (cfg.store_wait_ticks == 8'd0) ? 8'd1 : cfg.store_wait_ticks;

   always_comb begin
      take_start = (phase_ff == PH_IDLE) && req.start_req && (req.kind <= OP_SAVE);
      cur_phase  = take_start ? PH_RESET : phase_ff;
      cur_op     = take_start ? req.kind : op_ff;
      cur_lat    = take_start ? {req.upper_limit, req.lower_limit, req.resolution_in}
                              : lat_ff;
      cur_tick   = take_start ? 8'd0 : tick_ff;
      cur_bit    = take_start ? 3'd0 : bit_ff;
      cur_byte   = take_start ? 3'd0 : byte_ff;

      tick_inc   = cur_tick + 8'd1;
      writing    = cur_byte < write_count(cur_op);
      shift_rd   = (!writing && cur_tick == 8'd1) ? {req.line_level, shift_ff[7:1]}
                                                  : shift_ff;
      shift_done = writing ? {1'b0, shift_rd[7:1]} : shift_rd;
      next_byte  = cur_byte + 3'd1;
      rb_idx     = cur_byte - 3'(FIRST_READ);

      phase_in   = cur_phase;
      tick_in    = cur_tick;
      bit_in     = cur_bit;
      byte_in    = cur_byte;
      shift_in   = shift_ff;
      op_in      = cur_op;
      lat_in     = cur_lat;
      rb_in      = rb_ff;
      missing_in = missing_ff;
      drive      = 1'b1;
      busy       = 1'b0;
      done       = 1'b0;

      unique case (cur_phase)
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         PH_RESET: begin
            busy    = 1'b1;
            drive   = 1'b0;
            tick_in = tick_inc;
            if (tick_inc >= {1'b0, rst_len}) begin
               phase_in = PH_PRESENCE;
               tick_in  = 8'd0;
            end
         end
         PH_PRESENCE: begin
            busy = 1'b1;
            if (cur_tick < {3'd0, cfg.presence_wait_ticks}) begin
               tick_in = tick_inc;
            end else if (req.line_level) begin
               missing_in = 1'b1;
               if (cur_op == OP_READ_TEMP) begin
                  rb_in[0] = 8'd0;
                  rb_in[1] = 8'd0;
               end
               done     = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               missing_in = 1'b0;
               phase_in   = PH_RECOVERY;
               tick_in    = 8'd0;
            end
         end
         PH_RECOVERY: begin
            busy    = 1'b1;
            tick_in = tick_inc;
            if (tick_inc >= {2'd0, rec_len}) begin
               byte_in  = 3'd0;
               shift_in = write_value(cur_op, 3'd0, cur_lat);
               bit_in   = 3'd0;
               tick_in  = 8'd0;
               phase_in = PH_SLOT;
            end
         end
         PH_SLOT: begin
            busy = 1'b1;
            if (cur_tick == 8'd0) begin
               drive = 1'b0;
            end else begin
               drive = writing ? shift_ff[0] : 1'b1;
            end
            shift_in = shift_rd;
            if (cur_tick >= {4'd0, slot_len}) begin
               shift_in = shift_done;
               if (cur_bit == 3'd7) begin
                  if (!writing && cur_byte >= 3'(FIRST_READ)
                      && cur_byte < 3'(FIRST_READ + READ_BYTES)) begin
                     rb_in[rb_idx] = shift_done;
                  end
                  byte_in = next_byte;
                  if (next_byte >= total_count(cur_op)) begin
                     if (cur_op == OP_SAVE) begin
                        phase_in = PH_STORE;
                        tick_in  = 8'd0;
                     end else begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     shift_in = (next_byte < write_count(cur_op))
                                ? write_value(cur_op, next_byte, cur_lat) : 8'd0;
                     bit_in   = 3'd0;
                     tick_in  = 8'd0;
                     phase_in = PH_SLOT;
                  end
               end else begin
                  bit_in  = cur_bit + 3'd1;
                  tick_in = 8'd0;
               end
            end else begin
               tick_in = tick_inc;
            end
         end
         PH_STORE: begin
            busy    = 1'b1;
            tick_in = tick_inc;
            if (tick_inc >= store_len) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      res.line_drive      = drive;
      res.busy_res        = busy;
      res.done_res        = done;
      res.no_device       = missing_in;
      res.temperature     = $signed({rb_in[1], rb_in[0]});
      res.upper_limit_out = rb_in[2];
      res.lower_limit_out = rb_in[3];
      res.resolution_out  = rb_in[4][7:5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= 8'd0;
         bit_ff     <= 3'd0;
         byte_ff    <= 3'd0;
         shift_ff   <= 8'd0;
         op_ff      <= 3'd0;
         lat_ff     <= 18'd0;
         missing_ff <= 1'b0;
         for (int i = 0; i < READ_BYTES; i++) begin
            rb_ff[i] <= 8'd0;
         end
      end else if (item_take) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         byte_ff    <= byte_in;
         shift_ff   <= shift_in;
         op_ff      <= op_in;
         lat_ff     <= lat_in;
         missing_ff <= missing_in;
         rb_ff      <= rb_in;
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      item_take && res.done_res |-> res.busy_res)
      else $error("done without busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      item_take && res.done_res |=> phase_ff == PH_IDLE)
      else $error("transaction ended but sequencer not idle");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      item_take && phase_ff == PH_IDLE && !take_start |=> phase_ff == PH_IDLE)
      else $error("left idle without a start request");

   a_byte_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SLOT |-> byte_ff < total_count(op_ff))
      else $error("byte index past end of transaction");

endmodule

`default_nettype wire

@@ rtl/osm_rsp.sv @@
// osm_rsp: result register between the sequencer and the rsp channel
// depends on osm_pkg
`default_nettype none

module osm_rsp
   import osm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   output      logic    item_take,
   input  wire res_type res_in,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      res_type res_out
);

   logic    valid_ff;
   res_type res_ff;

   assign req_ready = !valid_ff || rsp_ready;
   assign item_take = req_valid && req_ready;
   assign rsp_valid = valid_ff;
   assign res_out   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (item_take) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire
